// ===== rtl/ipv4hb_pkg.sv =====
// ----------------------------------------------------------------------------
// ipv4hb_pkg
// Shared constants and types for the IPv4 header builder.
// ----------------------------------------------------------------------------
package ipv4hb_pkg;

  localparam int unsigned HDR_BYTES   = 20;
  localparam int unsigned POS_W       = 5;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(HDR_BYTES - 1);

  localparam logic [15:0] MAX_PAYLOAD  = 16'd65515;
  localparam logic [15:0] HDR_LEN      = 16'(HDR_BYTES);
  localparam logic [7:0]  VERSION_IHL  = 8'h45;
  localparam logic [7:0]  TOS_VALUE    = 8'h00;
  localparam logic [15:0] IDENT_VALUE  = 16'h0001;
  localparam logic [15:0] FLAGS_FRAG   = 16'h0000;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_ADDRESS = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TIME_TO_LIVE   = 1'd1;

  localparam logic [7:0] TTL_RESET = 8'd64;

  // one header to be serialized
  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [7:0]  ttl;
    logic [7:0]  proto;
    logic [15:0] total_len;
    logic [15:0] checksum;
  } hdr_desc_t;

endpackage

// ===== rtl/ipv4hb_front.sv =====
// ----------------------------------------------------------------------------
// ipv4hb_front
// Takes requests, clamps the length and builds the header checksum.
// ----------------------------------------------------------------------------
module ipv4hb_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [31:0]           in_destination_address,
  input  logic [7:0]            in_protocol_number,
  input  logic [15:0]           in_payload_length,
  input  logic [31:0]           src_addr,
  input  logic [7:0]            ttl,
  output logic                  push_valid,
  input  logic                  push_ready,
  output ipv4hb_pkg::hdr_desc_t push_desc
);
  import ipv4hb_pkg::*;

  logic        s1_valid_r, s1_valid_nxt;
  hdr_desc_t   s1_desc_r;
  hdr_desc_t   desc_nxt;
  logic [17:0] sum_a_r, sum_a_nxt;
  logic [17:0] sum_b_r, sum_b_nxt;
  logic [15:0] plen_sat;
  logic [18:0] sum_all;
  logic [16:0] fold1;
  logic [15:0] fold2;
  logic        accept;

  assign in_ready   = !s1_valid_r || push_ready;
  assign accept     = in_valid && in_ready;
  assign push_valid = s1_valid_r;

  always_comb begin
    plen_sat = (in_payload_length > MAX_PAYLOAD) ? MAX_PAYLOAD : in_payload_length;
    desc_nxt.src_addr  = src_addr;
    desc_nxt.dst_addr  = in_destination_address;
    desc_nxt.ttl       = ttl;
    desc_nxt.proto     = in_protocol_number;
    desc_nxt.total_len = plen_sat + HDR_LEN;
    desc_nxt.checksum  = 16'h0000;
    // checksum words split into two partial sums
    sum_a_nxt = {2'b00, VERSION_IHL, TOS_VALUE} + {2'b00, desc_nxt.total_len}
              + {2'b00, IDENT_VALUE} + {2'b00, FLAGS_FRAG} + {2'b00, ttl, in_protocol_number};
    sum_b_nxt = {2'b00, src_addr[31:16]} + {2'b00, src_addr[15:0]}
              + {2'b00, in_destination_address[31:16]}
              + {2'b00, in_destination_address[15:0]};
  end

  // end-around carry fold, then invert
  always_comb begin
    sum_all = {1'b0, sum_a_r} + {1'b0, sum_b_r};
    fold1   = {1'b0, sum_all[15:0]} + {14'd0, sum_all[18:16]};
    fold2   = fold1[15:0] + {15'd0, fold1[16]};
    push_desc          = s1_desc_r;
    push_desc.checksum = ~fold2;
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (push_ready) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_desc_r <= desc_nxt;
      sum_a_r   <= sum_a_nxt;
      sum_b_r   <= sum_b_nxt;
    end
  end

endmodule

// ===== rtl/ipv4hb_queue.sv =====
// ----------------------------------------------------------------------------
// ipv4hb_queue
// Small FIFO of header descriptors between front and back.
// ----------------------------------------------------------------------------
module ipv4hb_queue #(
  parameter int unsigned DEPTH = ipv4hb_pkg::QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_valid,
  output logic                  wr_ready,
  input  ipv4hb_pkg::hdr_desc_t wr_desc,
  output logic                  rd_valid,
  input  logic                  rd_ready,
  output ipv4hb_pkg::hdr_desc_t rd_desc
);
  import ipv4hb_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

  hdr_desc_t        slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign wr_ready = (cnt_r != FULL_CNT);
  assign rd_valid = (cnt_r != '0);
  assign rd_desc  = slot_r[rd_ptr_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_SLOT) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_SLOT) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wr_ptr_r] <= wr_desc;
    end
  end

endmodule

// ===== rtl/ipv4hb_back.sv =====
// ----------------------------------------------------------------------------
// ipv4hb_back
// Serializes one header descriptor into twenty bytes.
// ----------------------------------------------------------------------------
module ipv4hb_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        hd_valid,
  output logic                        hd_ready,
  input  ipv4hb_pkg::hdr_desc_t       hd_desc,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [7:0]                  out_header_byte,
  output logic [ipv4hb_pkg::POS_W-1:0] out_byte_position,
  output logic                        out_last_byte
);
  import ipv4hb_pkg::*;

  logic [POS_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       byte_r;
  logic [POS_W-1:0] pos_r;
  logic             last_r;
  logic [7:0]       byte_sel;
  logic             load;
  logic             at_last;

  assign load     = hd_valid && (!out_valid_r || out_ready);
  assign at_last  = (cnt_r == LAST_POS);
  assign hd_ready = load && at_last;

  assign out_valid         = out_valid_r;
  assign out_header_byte   = byte_r;
  assign out_byte_position = pos_r;
  assign out_last_byte     = last_r;

  always_comb begin
    case (cnt_r)
      5'd0:    byte_sel = VERSION_IHL;
      5'd1:    byte_sel = TOS_VALUE;
      5'd2:    byte_sel = hd_desc.total_len[15:8];
      5'd3:    byte_sel = hd_desc.total_len[7:0];
      5'd4:    byte_sel = IDENT_VALUE[15:8];
      5'd5:    byte_sel = IDENT_VALUE[7:0];
      5'd6:    byte_sel = FLAGS_FRAG[15:8];
      5'd7:    byte_sel = FLAGS_FRAG[7:0];
      5'd8:    byte_sel = hd_desc.ttl;
      5'd9:    byte_sel = hd_desc.proto;
      5'd10:   byte_sel = hd_desc.checksum[15:8];
      5'd11:   byte_sel = hd_desc.checksum[7:0];
      5'd12:   byte_sel = hd_desc.src_addr[31:24];
      5'd13:   byte_sel = hd_desc.src_addr[23:16];
      5'd14:   byte_sel = hd_desc.src_addr[15:8];
      5'd15:   byte_sel = hd_desc.src_addr[7:0];
      5'd16:   byte_sel = hd_desc.dst_addr[31:24];
      5'd17:   byte_sel = hd_desc.dst_addr[23:16];
      5'd18:   byte_sel = hd_desc.dst_addr[15:8];
      5'd19:   byte_sel = hd_desc.dst_addr[7:0];
      default: byte_sel = 8'h00;
    endcase
  end

  always_comb begin
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      cnt_nxt       = at_last ? '0 : cnt_r + 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= byte_sel;
      pos_r  <= cnt_r;
      last_r <= at_last;
    end
  end

endmodule

// ===== rtl/ipv4_header_builder_checksum.sv =====
// ----------------------------------------------------------------------------
// ipv4_header_builder_checksum
// Builds a 20-byte IPv4 header with checksum for each transmit request.
// ----------------------------------------------------------------------------
// Each request is turned into the IPv4 header in network byte order, one byte
// per output transfer with its offset and a last-byte flag. The output runs at
// one byte per cycle while out_ready is held high, a rate set by the byte-wide
// serializer in the back end. Requests pass through a one-stage front end
// (length clamp and partial sums registered, checksum fold and inversion on its
// output) and a two-entry descriptor queue, so a new request is taken while the
// previous header is still being sent. When the path is idle an accepted
// request is registered in the front end, written into the queue and loaded
// into the back end's output registers before its first byte is presented.
// Configuration writes take effect on the next request.
module ipv4_header_builder_checksum #(
  parameter int unsigned QUEUE_DEPTH = ipv4hb_pkg::QUEUE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [31:0]                       in_destination_address,
  input  logic [7:0]                        in_protocol_number,
  input  logic [15:0]                       in_payload_length,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [7:0]                        out_header_byte,
  output logic [ipv4hb_pkg::POS_W-1:0]      out_byte_position,
  output logic                              out_last_byte,
  input  logic                              cfg_wr_en,
  input  logic [ipv4hb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ipv4hb_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ipv4hb_pkg::*;

  logic [31:0] src_addr_r;
  logic [7:0]  ttl_r;
  logic        push_valid, push_ready;
  hdr_desc_t   push_desc;
  logic        hd_valid, hd_ready;
  hdr_desc_t   hd_desc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_addr_r <= '0;
      ttl_r      <= TTL_RESET;
    end else if (cfg_wr_en) begin
      if (cfg_index == REG_SOURCE_ADDRESS) begin
        src_addr_r <= cfg_data[31:0];
      end
      if (cfg_index == REG_TIME_TO_LIVE) begin
        ttl_r <= cfg_data[7:0];
      end
    end
  end

  ipv4hb_front u_front (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_destination_address (in_destination_address),
    .in_protocol_number     (in_protocol_number),
    .in_payload_length      (in_payload_length),
    .src_addr               (src_addr_r),
    .ttl                    (ttl_r),
    .push_valid             (push_valid),
    .push_ready             (push_ready),
    .push_desc              (push_desc)
  );

  ipv4hb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_desc  (push_desc),
    .rd_valid (hd_valid),
    .rd_ready (hd_ready),
    .rd_desc  (hd_desc)
  );

  ipv4hb_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .hd_valid          (hd_valid),
    .hd_ready          (hd_ready),
    .hd_desc           (hd_desc),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_header_byte   (out_header_byte),
    .out_byte_position (out_byte_position),
    .out_last_byte     (out_last_byte)
  );

endmodule

// ===== rtl/ipv4hb_checker.sv =====
// ----------------------------------------------------------------------------
// ipv4hb_checker
// Port-level checks for the IPv4 header builder, bound to the top level.
// ----------------------------------------------------------------------------
module ipv4hb_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [7:0]                   out_header_byte,
  input logic [ipv4hb_pkg::POS_W-1:0] out_byte_position,
  input logic                         out_last_byte
);
  import ipv4hb_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_header_byte)
      && $stable(out_byte_position) && $stable(out_last_byte))
    else $error("output changed while stalled");

  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_byte == (out_byte_position == LAST_POS)))
    else $error("last flag does not match final offset");

  a_first_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_byte_position == '0) |-> out_header_byte == VERSION_IHL)
    else $error("header does not start with version and ihl");

  // a header once started streams without gaps
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_byte |=> out_valid)
    else $error("gap inside a header");

endmodule

bind ipv4_header_builder_checksum ipv4hb_checker u_ipv4hb_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_header_byte   (out_header_byte),
  .out_byte_position (out_byte_position),
  .out_last_byte     (out_last_byte)
);
